[src/kvt_pkg.sv]
// kvt_pkg: shared constants, types and codes for the key/value table.
// Used by the channel interfaces, the front queue, the back engine and the top level.
// No dependencies.
`default_nettype none

package kvt_pkg;

  // Table geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int OP_W   = 2;
  localparam int KEY_W  = 64;
  localparam int ID_W   = 32;
  localparam int DATA_W = 64;

  // Request operation codes as they arrive on the channel
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Classified command: unused operation code becomes a no-op
  typedef enum logic [1:0] {
    CMD_LOOKUP,
    CMD_INSERT,
    CMD_DELETE,
    CMD_NOP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic               kind;
    logic [KEY_W-1:0]   key;   // normalized: id keys have upper half cleared
    logic [DATA_W-1:0]  data;
  } cmd_t;

  // One stored table entry
  typedef struct packed {
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Back engine states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SHIFT,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

[src/kvt_req_if.sv]
// kvt_req_if: request channel (valid/ready plus request payload).
// Depends on kvt_pkg for field widths.
`default_nettype none

interface kvt_req_if;
  logic                      valid;
  logic                      ready;
  logic [kvt_pkg::OP_W-1:0]   operation;
  logic                      key_kind;
  logic [kvt_pkg::KEY_W-1:0]  key_value;
  logic [kvt_pkg::DATA_W-1:0] data_word;

  modport source (output valid, operation, key_kind, key_value, data_word, input ready);
  modport sink   (input valid, operation, key_kind, key_value, data_word, output ready);
endinterface

`default_nettype wire

[src/kvt_rsp_if.sv]
// kvt_rsp_if: response channel (valid/ready plus result payload).
// Depends on kvt_pkg for field widths.
`default_nettype none

interface kvt_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      success;
  logic [kvt_pkg::DATA_W-1:0] read_data;

  modport source (output valid, success, read_data, input ready);
  modport sink   (input valid, success, read_data, output ready);
endinterface

`default_nettype wire

[src/kvt_ram.sv]
// kvt_ram: generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module kvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/kvt_front.sv]
// kvt_front: accepts request transactions, classifies them and queues commands.
// Depends on kvt_pkg and kvt_req_if.
`default_nettype none

module kvt_front (
  input  logic           clk,
  input  logic           rst,
  kvt_req_if.sink        req,
  output logic           cmd_valid,
  output kvt_pkg::cmd_t  cmd,
  input  logic           cmd_pop
);

  kvt_pkg::cmd_t                  q_mem [kvt_pkg::QUEUE_DEPTH];
  logic [kvt_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [kvt_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [kvt_pkg::Q_CNT_W-1:0]    fill;
  kvt_pkg::cmd_t                  cmd_in;
  logic                           push;
  logic                           pop;

  // Classify operation and normalize key
  always_comb begin
    cmd_in.kind = req.key_kind;
    cmd_in.data = req.data_word;
    if (req.key_kind) begin
      cmd_in.key = req.key_value;
    end else begin
      cmd_in.key = {{(kvt_pkg::KEY_W - kvt_pkg::ID_W){1'b0}},
                    req.key_value[kvt_pkg::ID_W-1:0]};
    end
    unique case (req.operation)
      kvt_pkg::OP_LOOKUP: cmd_in.op = kvt_pkg::CMD_LOOKUP;
      kvt_pkg::OP_INSERT: cmd_in.op = kvt_pkg::CMD_INSERT;
      kvt_pkg::OP_DELETE: cmd_in.op = kvt_pkg::CMD_DELETE;
      default:            cmd_in.op = kvt_pkg::CMD_NOP;
    endcase
  end

  // Queue handshake
  assign req.ready = (fill != kvt_pkg::Q_CNT_W'(kvt_pkg::QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_mem[rd_ptr];

  // Queue storage (payload, no reset)
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        if (wr_ptr == kvt_pkg::Q_PTR_W'(kvt_pkg::QUEUE_DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + kvt_pkg::Q_PTR_W'(1);
        end
      end
      if (pop) begin
        if (rd_ptr == kvt_pkg::Q_PTR_W'(kvt_pkg::QUEUE_DEPTH - 1)) begin
          rd_ptr <= '0;
        end else begin
          rd_ptr <= rd_ptr + kvt_pkg::Q_PTR_W'(1);
        end
      end
      if (push && !pop) begin
        fill <= fill + kvt_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - kvt_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/kvt_back.sv]
// kvt_back: executes queued commands against the entry RAM and registers results.
// Depends on kvt_pkg, kvt_ram and kvt_rsp_if.
`default_nettype none

module kvt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  kvt_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  kvt_rsp_if.source      rsp
);

  kvt_pkg::back_state_t          state;
  kvt_pkg::back_state_t          state_next;

  // Current command
  kvt_pkg::cmd_op_t              cur_op;
  logic                          cur_kind;
  logic [kvt_pkg::KEY_W-1:0]     cur_key;

  logic [kvt_pkg::CNT_W-1:0]     count;

  // Scan pipeline: issue at scan_ptr, check at chk_idx
  logic [kvt_pkg::IDX_W-1:0]     scan_ptr;
  logic                          issue_more;
  logic                          chk_vld;
  logic [kvt_pkg::IDX_W-1:0]     chk_idx;

  // Shift pipeline: read sh_ptr, write the registered read data to wr_idx
  logic [kvt_pkg::CNT_W-1:0]     sh_ptr;
  logic [kvt_pkg::CNT_W-1:0]     sh_prev;
  logic                          wr_pend;
  logic [kvt_pkg::IDX_W-1:0]     wr_idx;

  // Result holding and output register
  logic                          res_success;
  logic [kvt_pkg::DATA_W-1:0]    res_data;
  logic                          out_valid;
  logic                          out_success;
  logic [kvt_pkg::DATA_W-1:0]    out_data;

  // RAM port
  logic                          ram_we;
  logic [kvt_pkg::IDX_W-1:0]     ram_waddr;
  logic [kvt_pkg::ENTRY_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic [kvt_pkg::IDX_W-1:0]     ram_raddr;
  logic [kvt_pkg::ENTRY_W-1:0]   ram_rdata;
  kvt_pkg::entry_t               q_entry;

  logic                          room;
  logic                          hit;
  logic                          scan_miss_end;
  logic                          shift_more;
  logic                          shift_end;
  logic                          out_free;

  // Newest occupied slot for the scan start
  function automatic logic [kvt_pkg::IDX_W-1:0] sh_ptr_init(
      input logic [kvt_pkg::CNT_W-1:0] n);
    logic [kvt_pkg::CNT_W-1:0] last;
    last = n - kvt_pkg::CNT_W'(1);
    return last[kvt_pkg::IDX_W-1:0];
  endfunction

  kvt_ram #(
    .WIDTH (kvt_pkg::ENTRY_W),
    .DEPTH (kvt_pkg::CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status terms
  assign q_entry       = kvt_pkg::entry_t'(ram_rdata);
  assign room          = (count < kvt_pkg::CNT_W'(kvt_pkg::CAPACITY));
  assign hit           = chk_vld && (q_entry.kind == cur_kind) && (q_entry.key == cur_key);
  assign scan_miss_end = chk_vld && !hit && (chk_idx == '0);
  assign shift_more    = (sh_ptr < count);
  assign shift_end     = !shift_more && !wr_pend;
  assign sh_prev       = sh_ptr - kvt_pkg::CNT_W'(1);
  assign out_free      = !out_valid || rsp.ready;

  assign rsp.valid     = out_valid;
  assign rsp.success   = out_success;
  assign rsp.read_data = out_data;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      kvt_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            kvt_pkg::CMD_INSERT,
            kvt_pkg::CMD_NOP:    state_next = kvt_pkg::BK_DONE;
            kvt_pkg::CMD_LOOKUP,
            kvt_pkg::CMD_DELETE: begin
              state_next = (count == '0) ? kvt_pkg::BK_DONE : kvt_pkg::BK_SCAN;
            end
          endcase
        end
      end
      kvt_pkg::BK_SCAN: begin
        if (hit) begin
          state_next = (cur_op == kvt_pkg::CMD_DELETE) ? kvt_pkg::BK_SHIFT
                                                       : kvt_pkg::BK_DONE;
        end else if (scan_miss_end) begin
          state_next = kvt_pkg::BK_DONE;
        end
      end
      kvt_pkg::BK_SHIFT: begin
        if (shift_end) begin
          state_next = kvt_pkg::BK_DONE;
        end
      end
      kvt_pkg::BK_DONE: begin
        if (out_free) begin
          state_next = kvt_pkg::BK_IDLE;
        end
      end
    endcase
  end

  // Queue pop and RAM controls
  always_comb begin
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wr_idx;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = scan_ptr;
    unique case (state)
      kvt_pkg::BK_IDLE: begin
        cmd_pop   = cmd_valid;
        ram_we    = cmd_valid && (cmd.op == kvt_pkg::CMD_INSERT) && room;
        ram_waddr = count[kvt_pkg::IDX_W-1:0];
        ram_wdata = {cmd.kind, cmd.key, cmd.data};
      end
      kvt_pkg::BK_SCAN: begin
        ram_re    = issue_more && !hit && !scan_miss_end;
        ram_raddr = scan_ptr;
      end
      kvt_pkg::BK_SHIFT: begin
        ram_we    = wr_pend;
        ram_waddr = wr_idx;
        ram_wdata = ram_rdata;
        ram_re    = shift_more;
        ram_raddr = sh_ptr[kvt_pkg::IDX_W-1:0];
      end
      kvt_pkg::BK_DONE: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kvt_pkg::BK_IDLE;
      count      <= '0;
      issue_more <= 1'b0;
      chk_vld    <= 1'b0;
      wr_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      // Output valid: load a finished result, clear once taken
      if ((state == kvt_pkg::BK_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        kvt_pkg::BK_IDLE: begin
          if (cmd_valid) begin
            cur_op      <= cmd.op;
            cur_kind    <= cmd.kind;
            cur_key     <= cmd.key;
            scan_ptr    <= sh_ptr_init(count);
            issue_more  <= 1'b1;
            chk_vld     <= 1'b0;
            res_success <= 1'b0;
            res_data    <= '0;
            if ((cmd.op == kvt_pkg::CMD_INSERT) && room) begin
              count       <= count + kvt_pkg::CNT_W'(1);
              res_success <= 1'b1;
            end
          end
        end
        kvt_pkg::BK_SCAN: begin
          if (hit) begin
            res_success <= 1'b1;
            res_data    <= (cur_op == kvt_pkg::CMD_LOOKUP) ? q_entry.data : '0;
            sh_ptr      <= kvt_pkg::CNT_W'(chk_idx) + kvt_pkg::CNT_W'(1);
            wr_pend     <= 1'b0;
            chk_vld     <= 1'b0;
          end else if (scan_miss_end) begin
            chk_vld <= 1'b0;
          end else begin
            chk_vld <= issue_more;
            chk_idx <= scan_ptr;
            if (issue_more) begin
              if (scan_ptr == '0) begin
                issue_more <= 1'b0;
              end else begin
                scan_ptr <= scan_ptr - kvt_pkg::IDX_W'(1);
              end
            end
          end
        end
        kvt_pkg::BK_SHIFT: begin
          wr_pend <= shift_more;
          wr_idx  <= sh_prev[kvt_pkg::IDX_W-1:0];
          if (shift_more) begin
            sh_ptr <= sh_ptr + kvt_pkg::CNT_W'(1);
          end
          if (shift_end) begin
            count <= count - kvt_pkg::CNT_W'(1);
          end
        end
        kvt_pkg::BK_DONE: begin
          if (out_free) begin
            out_success <= res_success;
            out_data    <= res_data;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= kvt_pkg::CNT_W'(kvt_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == kvt_pkg::BK_IDLE && cmd_valid && cmd.op == kvt_pkg::CMD_INSERT && room)
    |=> count == $past(count) + kvt_pkg::CNT_W'(1))
    else $error("insert with room did not add an entry");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == kvt_pkg::BK_SHIFT && shift_end) |=> count == $past(count) - kvt_pkg::CNT_W'(1))
    else $error("completed delete did not remove one entry");

  a_ram_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == kvt_pkg::BK_IDLE || state == kvt_pkg::BK_SHIFT))
    else $error("entry RAM written outside insert or shift");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == kvt_pkg::BK_DONE)
    else $error("result presented without a finished command");
`endif

endmodule

`default_nettype wire

[src/key_value_table_core.sv]
// key_value_table_core: top level of the bounded key/value table.
// Depends on kvt_pkg, kvt_req_if, kvt_rsp_if, kvt_front and kvt_back.
//
//   channel  dir  fields                                           accepted when
//   req      in   operation, key_kind, key_value, data_word        req.valid && req.ready
//   rsp      out  success, read_data                               rsp.valid && rsp.ready
//
// Insert and the unused code go from the queue head to BK_DONE without a scan.
// Lookup and delete scan the entries from the newest down to the hit (or all
// entries on a miss), one read per entry through the single read port of the
// entry RAM; on an empty table they skip the scan. A delete hit then packs the
// table by moving every entry newer than the hit (if any) down one slot. Reset
// clears the entry count and the queue; there is no clearing pass.
// Up to two requests queue in front while the back side works or the result waits.
`default_nettype none

module key_value_table_core (
  input  logic       clk,
  input  logic       rst,
  kvt_req_if.sink    req,
  kvt_rsp_if.source  rsp
);

  logic           cmd_valid;
  kvt_pkg::cmd_t  cmd;
  logic           cmd_pop;

  kvt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  kvt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
